FILE: src/spq_pkg.sv
// Shared types and codes for the sorted priority queue.
package spq_pkg;

    localparam int DEFAULT_CAPACITY = 16;

    localparam int VALUE_W = 8;
    localparam int PRI_W   = 8;
    localparam int STAT_W  = 2;
    localparam int OCC_W   = 5;

    localparam logic OP_INSERT = 1'b0;
    localparam logic OP_REMOVE = 1'b1;

    localparam logic [STAT_W-1:0] ST_DONE  = 2'd0;
    localparam logic [STAT_W-1:0] ST_FULL  = 2'd1;
    localparam logic [STAT_W-1:0] ST_EMPTY = 2'd2;

    // priority in the upper byte, payload in the lower byte
    typedef struct packed {
        logic [PRI_W-1:0]   pri;
        logic [VALUE_W-1:0] value;
    } entry_t;

endpackage

FILE: src/sorted_priority_queue_unit.sv
// Sorted priority queue: circular entry store with insertion by backward scan.
//
// Usage: present operation, item_value and item_priority and raise start while
// busy is low; the request is taken at that clock edge. Each request gives
// exactly one result, shown for one cycle with done high: status, out_value,
// out_priority and occupancy (entries held after the request).
// The receiver cannot stall; a result must be taken in its done cycle.
//
// Request flow, from accept to the done cycle:
//   remove on empty, insert when full, insert into empty store: settled in S_IDLE
//   remove of the front entry: one store read of the head slot (S_POP)
//   insert into a non-empty store: every held entry of strictly lower
//   priority is read and moved one slot toward the tail, one per cycle
//   through the single store read port, then the new entry is written.
// A new request may be accepted in the done cycle of the previous one.
//
// Entries live in a circular store (head = front, tail = next free slot), so
// a remove only advances the head. An insert walks back from the tail,
// moving lower-priority entries up by one, and writes the new entry into the
// gap. While entries are moved, the slot read is two below the slot written.
// Reset clears head, tail and count; the store contents are left unset and
// only data from slots holding live entries is ever used.
module sorted_priority_queue_unit #(
    parameter int CAPACITY = spq_pkg::DEFAULT_CAPACITY
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    output logic                         busy,
    input  logic                         operation,
    input  logic [spq_pkg::VALUE_W-1:0]  item_value,
    input  logic [spq_pkg::PRI_W-1:0]    item_priority,
    output logic                         done,
    output logic [spq_pkg::STAT_W-1:0]   status,
    output logic [spq_pkg::VALUE_W-1:0]  out_value,
    output logic [spq_pkg::PRI_W-1:0]    out_priority,
    output logic [spq_pkg::OCC_W-1:0]    occupancy
);

    localparam int AW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);

    // controller states
    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_POP   = 2'd1;
    localparam logic [1:0] S_INS   = 2'd2;
    localparam logic [1:0] S_PLACE = 2'd3;

    logic [1:0]      state_reg, state_next;
    logic [AW-1:0]   head_reg, head_next;
    logic [AW-1:0]   tail_reg, tail_next;
    logic [CW-1:0]   count_reg, count_next;
    logic [AW-1:0]   ptr_reg, ptr_next;     // slot to fill during insert scan
    logic [CW-1:0]   left_reg, left_next;   // entries not yet examined
    spq_pkg::entry_t new_reg, new_next;

    logic                        done_reg, done_next;
    logic [spq_pkg::STAT_W-1:0]  status_reg, status_next;
    logic [spq_pkg::VALUE_W-1:0] oval_reg, oval_next;
    logic [spq_pkg::PRI_W-1:0]   opri_reg, opri_next;

    // store port
    logic            we;
    logic [AW-1:0]   waddr;
    spq_pkg::entry_t wdata;
    logic [AW-1:0]   raddr;
    spq_pkg::entry_t rdata;

    logic [AW-1:0]   ptr_dec;
    logic [AW-1:0]   tail_dec;
    logic [CW+spq_pkg::OCC_W-1:0] count_ext;

    function automatic logic [AW-1:0] ptr_inc(input logic [AW-1:0] p);
        ptr_inc = (p == AW'(CAPACITY - 1)) ? '0 : p + AW'(1);
    endfunction

    function automatic logic [AW-1:0] ptr_dec_f(input logic [AW-1:0] p);
        ptr_dec_f = (p == '0) ? AW'(CAPACITY - 1) : p - AW'(1);
    endfunction

    spq_store #(
        .CAPACITY (CAPACITY),
        .AW       (AW)
    ) u_store (
        .clk   (clk),
        .we    (we),
        .waddr (waddr),
        .wdata (wdata),
        .raddr (raddr),
        .rdata (rdata)
    );

    assign ptr_dec  = ptr_dec_f(ptr_reg);
    assign tail_dec = ptr_dec_f(tail_reg);

    always_comb
    begin
        state_next  = state_reg;
        head_next   = head_reg;
        tail_next   = tail_reg;
        count_next  = count_reg;
        ptr_next    = ptr_reg;
        left_next   = left_reg;
        new_next    = new_reg;
        done_next   = 1'b0;
        status_next = status_reg;
        oval_next   = oval_reg;
        opri_next   = opri_reg;
        we          = 1'b0;
        waddr       = ptr_reg;
        wdata       = new_reg;
        raddr       = tail_dec;

        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    oval_next = '0;
                    opri_next = '0;
                    if (operation == spq_pkg::OP_REMOVE)
                    begin
                        if (count_reg == '0)
                        begin
                            done_next   = 1'b1;
                            status_next = spq_pkg::ST_EMPTY;
                        end
                        else
                        begin
                            raddr      = head_reg;
                            state_next = S_POP;
                        end
                    end
                    else if (count_reg == CW'(CAPACITY))
                    begin
                        done_next   = 1'b1;
                        status_next = spq_pkg::ST_FULL;
                    end
                    else if (count_reg == '0)
                    begin
                        we          = 1'b1;
                        waddr       = tail_reg;
                        wdata       = '{pri: item_priority, value: item_value};
                        tail_next   = ptr_inc(tail_reg);
                        count_next  = count_reg + CW'(1);
                        done_next   = 1'b1;
                        status_next = spq_pkg::ST_DONE;
                    end
                    else
                    begin
                        // start the backward scan at the last held entry
                        raddr      = tail_dec;
                        ptr_next   = tail_reg;
                        left_next  = count_reg;
                        new_next   = '{pri: item_priority, value: item_value};
                        state_next = S_INS;
                    end
                end
            end

            S_POP:
            begin
                head_next   = ptr_inc(head_reg);
                count_next  = count_reg - CW'(1);
                done_next   = 1'b1;
                status_next = spq_pkg::ST_DONE;
                oval_next   = rdata.value;
                opri_next   = rdata.pri;
                state_next  = S_IDLE;
            end

            S_INS:
            begin
                we = 1'b1;
                if (rdata.pri >= new_reg.pri)
                begin
                    // new entry goes right behind this one
                    wdata       = new_reg;
                    tail_next   = ptr_inc(tail_reg);
                    count_next  = count_reg + CW'(1);
                    done_next   = 1'b1;
                    status_next = spq_pkg::ST_DONE;
                    state_next  = S_IDLE;
                end
                else
                begin
                    // move lower-priority entry one slot toward the tail
                    wdata     = rdata;
                    ptr_next  = ptr_dec;
                    left_next = left_reg - CW'(1);
                    raddr     = ptr_dec_f(ptr_dec);
                    if (left_reg == CW'(1))
                    begin
                        state_next = S_PLACE;
                    end
                end
            end

            S_PLACE:
            begin
                // every held entry was lower: new entry becomes the front
                we          = 1'b1;
                wdata       = new_reg;
                tail_next   = ptr_inc(tail_reg);
                count_next  = count_reg + CW'(1);
                done_next   = 1'b1;
                status_next = spq_pkg::ST_DONE;
                state_next  = S_IDLE;
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            head_reg  <= '0;
            tail_reg  <= '0;
            count_reg <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            head_reg  <= head_next;
            tail_reg  <= tail_next;
            count_reg <= count_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        ptr_reg    <= ptr_next;
        left_reg   <= left_next;
        new_reg    <= new_next;
        status_reg <= status_next;
        oval_reg   <= oval_next;
        opri_reg   <= opri_next;
    end

    // count stays put through the done cycle, so it is the post-request count
    assign count_ext = {{spq_pkg::OCC_W{1'b0}}, count_reg};

    assign busy         = (state_reg != S_IDLE);
    assign done         = done_reg;
    assign status       = status_reg;
    assign out_value    = oval_reg;
    assign out_priority = opri_reg;
    assign occupancy    = count_ext[spq_pkg::OCC_W-1:0];

endmodule

FILE: src/spq_store.sv
// Entry store: one write port, one read port, registered read data.
module spq_store #(
    parameter int CAPACITY = spq_pkg::DEFAULT_CAPACITY,
    parameter int AW       = $clog2(CAPACITY)
) (
    input  logic            clk,
    input  logic            we,
    input  logic [AW-1:0]   waddr,
    input  spq_pkg::entry_t wdata,
    input  logic [AW-1:0]   raddr,
    output spq_pkg::entry_t rdata
);

    spq_pkg::entry_t mem [CAPACITY];
    spq_pkg::entry_t rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

FILE: tb/priority_queue_checker.sv
// Checker for the sorted priority queue: predicts each request's result and compares.
`timescale 1ns / 100ps

module priority_queue_checker #(
    parameter int CAPACITY = spq_pkg::DEFAULT_CAPACITY
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    input  logic                         busy,
    input  logic                         operation,
    input  logic [spq_pkg::VALUE_W-1:0]  item_value,
    input  logic [spq_pkg::PRI_W-1:0]    item_priority,
    input  logic                         done,
    input  logic [spq_pkg::STAT_W-1:0]   status,
    input  logic [spq_pkg::VALUE_W-1:0]  out_value,
    input  logic [spq_pkg::PRI_W-1:0]    out_priority,
    input  logic [spq_pkg::OCC_W-1:0]    occupancy,
    output int                           fail_count,
    output int                           pending
);

    typedef struct packed {
        logic [spq_pkg::STAT_W-1:0]  status;
        logic [spq_pkg::VALUE_W-1:0] value;
        logic [spq_pkg::PRI_W-1:0]   pri;
        logic [spq_pkg::OCC_W-1:0]   occ;
    } queue_result_t;

    spq_pkg::entry_t held_entries[$];      // front at index 0
    queue_result_t   expected_results[$];
    queue_result_t   want;
    int unsigned     result_idx = 0;
    int              errors = 0;

    assign fail_count = errors;

    task automatic flag_error(input string msg);
        $display("ERROR t=%0t result %0d: %s", $time, result_idx, msg);
        errors++;
    endtask

    // sorted insert behind all entries of greater or equal priority; pop from front
    function automatic queue_result_t apply_request(
        input logic                        op,
        input logic [spq_pkg::VALUE_W-1:0] ins_val,
        input logic [spq_pkg::PRI_W-1:0]   ins_pri);
        queue_result_t   r;
        spq_pkg::entry_t head;
        int              slot;
        r = '0;
        if (op == spq_pkg::OP_INSERT)
        begin
            if (held_entries.size() >= CAPACITY)
                r.status = spq_pkg::ST_FULL;
            else
            begin
                slot = 0;
                while (slot < held_entries.size() && held_entries[slot].pri >= ins_pri)
                    slot++;
                held_entries.insert(slot, spq_pkg::entry_t'{pri: ins_pri, value: ins_val});
                r.status = spq_pkg::ST_DONE;
            end
        end
        else if (held_entries.size() == 0)
            r.status = spq_pkg::ST_EMPTY;
        else
        begin
            head = held_entries.pop_front();
            r.status = spq_pkg::ST_DONE;
            r.value  = head.value;
            r.pri    = head.pri;
        end
        r.occ = spq_pkg::OCC_W'(held_entries.size());
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            held_entries.delete();
            expected_results.delete();
            pending <= 0;
        end
        else
        begin
            // results first: a request taken at this edge cannot finish at it
            if (done)
            begin
                if (expected_results.size() == 0)
                    flag_error($sformatf("result with no request pending (status %0d)", status));
                else
                begin
                    want = expected_results.pop_front();
                    if (status !== want.status)
                        flag_error($sformatf("status %0d, expected %0d", status, want.status));
                    if (out_value !== want.value)
                        flag_error($sformatf("out_value %0h, expected %0h",
                                             out_value, want.value));
                    if (out_priority !== want.pri)
                        flag_error($sformatf("out_priority %0h, expected %0h",
                                             out_priority, want.pri));
                    if (occupancy !== want.occ)
                        flag_error($sformatf("occupancy %0d, expected %0d",
                                             occupancy, want.occ));
                end
                result_idx++;
            end
            if (start && !busy)
                expected_results.push_back(apply_request(operation, item_value, item_priority));
            pending <= expected_results.size();
        end
    end

endmodule

FILE: tb/sorted_priority_queue_unit_tb.sv
// Top of the sorted priority queue testbench: clock, reset, request stimulus and verdict.
`timescale 1ns / 100ps

module sorted_priority_queue_unit_tb;

    localparam int CAPACITY     = spq_pkg::DEFAULT_CAPACITY;
    localparam int RANDOM_COUNT = 1700;
    // worst single request is an insert that shifts 15 entries;
    // sender gaps are geometric, so a long quiet spell means a hang
    localparam int STALL_LIMIT  = 2000;

    logic                         clk;
    logic                         rst_n         = 1'b0;
    logic                         start         = 1'b0;
    logic                         operation     = spq_pkg::OP_INSERT;
    logic [spq_pkg::VALUE_W-1:0]  item_value    = '0;
    logic [spq_pkg::PRI_W-1:0]    item_priority = '0;
    logic                         busy;
    logic                         done;
    logic [spq_pkg::STAT_W-1:0]   status;
    logic [spq_pkg::VALUE_W-1:0]  out_value;
    logic [spq_pkg::PRI_W-1:0]    out_priority;
    logic [spq_pkg::OCC_W-1:0]    occupancy;

    int                           fail_count;
    int                           pending;
    int unsigned                  quiet_cycles = 0;

    sorted_priority_queue_unit #(.CAPACITY(CAPACITY)) dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (start),
        .busy          (busy),
        .operation     (operation),
        .item_value    (item_value),
        .item_priority (item_priority),
        .done          (done),
        .status        (status),
        .out_value     (out_value),
        .out_priority  (out_priority),
        .occupancy     (occupancy)
    );

    // the checker sees the same pins and does all prediction and comparison
    priority_queue_checker #(.CAPACITY(CAPACITY)) u_checker (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (start),
        .busy          (busy),
        .operation     (operation),
        .item_value    (item_value),
        .item_priority (item_priority),
        .done          (done),
        .status        (status),
        .out_value     (out_value),
        .out_priority  (out_priority),
        .occupancy     (occupancy),
        .fail_count    (fail_count),
        .pending       (pending)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // Watchdog: any cycle where neither a request nor a result is taken counts
    // toward the limit. Covers a stuck busy as well as a lost result.
    always @(posedge clk)
    begin
        if (!rst_n || (start && !busy) || done)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("TIMEOUT after %0d quiet cycles, %0d results outstanding",
                     quiet_cycles, pending);
            $display("FAIL sorted_priority_queue_unit");
            $finish;
        end
    end

    // Issue one request and return at the edge that takes it. When allowed,
    // start drops for a random number of cycles first. start is only driven
    // once per time step, so back-to-back requests keep it high throughout.
    task automatic send_request(input logic op, input logic [spq_pkg::VALUE_W-1:0] val,
                                input logic [spq_pkg::PRI_W-1:0] pri, input bit may_idle);
        while (may_idle && $urandom_range(99) < 36)
        begin
            start <= 1'b0;
            @(posedge clk);
        end
        start         <= 1'b1;
        operation     <= op;
        item_value    <= val;
        item_priority <= pri;
        // busy read right after the edge is its value at that edge
        @(posedge clk);
        while (busy)
            @(posedge clk);
    endtask

    initial
    begin
        int unsigned                k;
        int unsigned                insert_pct;
        logic                       op;
        logic [spq_pkg::PRI_W-1:0]  pri;

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // ---- directed ----
        // pop on an empty queue; payload fields carry junk that must be ignored
        send_request(spq_pkg::OP_REMOVE, 8'hA5, 8'h5A, 1'b0);
        // priority/payload extremes
        send_request(spq_pkg::OP_INSERT, 8'h00, 8'hFF, 1'b0);
        send_request(spq_pkg::OP_INSERT, 8'hFF, 8'h00, 1'b0);
        // ties: later arrivals must queue behind earlier ones of equal priority
        send_request(spq_pkg::OP_INSERT, 8'h11, 8'h80, 1'b0);
        send_request(spq_pkg::OP_INSERT, 8'h22, 8'h80, 1'b0);
        send_request(spq_pkg::OP_INSERT, 8'h33, 8'hFF, 1'b0);
        send_request(spq_pkg::OP_INSERT, 8'h44, 8'h00, 1'b0);
        // top up to capacity with spread priorities, some landing mid-queue
        for (k = 0; k < CAPACITY - 6; k++)
            send_request(spq_pkg::OP_INSERT, spq_pkg::VALUE_W'(8'h50 + k),
                         spq_pkg::PRI_W'(k * 28 + 1), 1'b1);
        // insert refused when full
        send_request(spq_pkg::OP_INSERT, 8'h99, 8'hFF, 1'b0);
        // a few pops to check the head order
        repeat (3) send_request(spq_pkg::OP_REMOVE, 8'h00, 8'h00, 1'b1);

        // ---- random ----
        // Insert ratio is redrawn every 32 requests so the queue swings between
        // empty and full; narrow priority ranges produce plenty of ties.
        // Requests 600..899 go back to back with no sender gaps.
        insert_pct = 50;
        for (k = 0; k < RANDOM_COUNT; k++)
        begin
            if (k % 32 == 0)
            begin
                case ($urandom_range(2))
                    0:       insert_pct = 20;
                    1:       insert_pct = 50;
                    default: insert_pct = 85;
                endcase
            end
            op = ($urandom_range(99) < insert_pct) ? spq_pkg::OP_INSERT : spq_pkg::OP_REMOVE;
            case ($urandom_range(9))
                0:          pri = $urandom_range(1) ? 8'hFF : 8'h00;
                1, 2, 3, 4: pri = spq_pkg::PRI_W'($urandom_range(0, 3));
                default:    pri = spq_pkg::PRI_W'($urandom);
            endcase
            send_request(op, spq_pkg::VALUE_W'($urandom), pri, !(k >= 600 && k < 900));
        end
        start <= 1'b0;

        // drain: pending lags by one edge, so step once before looking at it
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        // settle past the longest request latency to catch stray results
        repeat (24) @(posedge clk);

        if (fail_count == 0)
            $display("PASS sorted_priority_queue_unit");
        else
            $display("FAIL sorted_priority_queue_unit");
        $finish;
    end

endmodule

FILE: files.f
src/spq_pkg.sv
src/spq_store.sv
src/sorted_priority_queue_unit.sv
tb/priority_queue_checker.sv
tb/sorted_priority_queue_unit_tb.sv
